// ----- src/dna_trie_insert_and_match_assert.svh -----
// Assertion macros shared by the trie block.
`ifndef DNA_TRIE_INSERT_AND_MATCH_ASSERT_SVH
`define DNA_TRIE_INSERT_AND_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define DTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trie block assertion failed");

// Check that cons holds in the cycle after ante.
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trie block assertion failed");

`else

`define DTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/dtm_pkg.sv -----
package dtm_pkg;

    // Node pool size and derived pointer widths
    localparam int NODE_COUNT = 1024;
    localparam int PTR_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = PTR_W + 1;

    // Field and register widths
    localparam int SYM_W   = 8;
    localparam int QLEN_W  = 5;
    localparam int TOTAL_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(10);

    // Register index, taken from paddr above the byte offset
    localparam logic REG_QUERY_LENGTH = 1'b0;

    // Request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    // DNA letters, lower-case ASCII
    localparam logic [SYM_W-1:0] CHAR_A = 8'h61;
    localparam logic [SYM_W-1:0] CHAR_T = 8'h74;
    localparam logic [SYM_W-1:0] CHAR_C = 8'h63;
    localparam logic [SYM_W-1:0] CHAR_G = 8'h67;

    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_T = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;
    localparam logic [1:0] SLOT_G = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;

    // One trie node: four child pointers, zero means no child
    typedef ptr_t [3:0] node_t;

    typedef struct packed {
        logic       is_dna;
        logic [1:0] slot;
    } letter_t;

    // Node memory access for one cycle
    typedef struct packed {
        logic  wr_en;
        ptr_t  wr_addr;
        node_t wr_data;
        ptr_t  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic               op_done;
        logic               matched;
        logic               pool_overflow;
        logic [TOTAL_W-1:0] strings_checked;
        logic [TOTAL_W-1:0] strings_mapped;
    } result_t;

    // Map a character to its child slot
    function automatic letter_t letter_slot(input logic [SYM_W-1:0] sym);
        letter_t l;
        l.is_dna = 1'b1;
        l.slot   = SLOT_A;
        case (sym)
            CHAR_A: l.slot = SLOT_A;
            CHAR_T: l.slot = SLOT_T;
            CHAR_C: l.slot = SLOT_C;
            CHAR_G: l.slot = SLOT_G;
            default: l.is_dna = 1'b0;
        endcase
        return l;
    endfunction

endpackage

// ----- src/dtm_node_mem.sv -----
module dtm_node_mem
    import dtm_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output node_t    rd_data
);

    node_t mem [NODE_COUNT];

    // Write one node and read one node; the read data is registered
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// ----- src/dtm_cfg_regs.sv -----
module dtm_cfg_regs
    import dtm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [QLEN_W-1:0]  query_length
);

    logic [QLEN_W-1:0] query_length_reg;
    logic              reg_index;
    logic              wr_strobe;

    assign reg_index = paddr[PADDR_W-1];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    // Update query length on the access cycle of a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_length_reg <= QLEN_RESET;
        end else if (wr_strobe && (reg_index == REG_QUERY_LENGTH)) begin
            query_length_reg <= pwdata[QLEN_W-1:0];
        end
    end

    // Return register contents on read
    always_comb begin
        prdata = '0;
        if (reg_index == REG_QUERY_LENGTH) begin
            prdata = PDATA_W'(query_length_reg);
        end
    end

    assign query_length = query_length_reg;

endmodule

// ----- src/dtm_walker.sv -----
module dtm_walker
    import dtm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic              s_last_char,
    input  logic [QLEN_W-1:0] query_length,
    output mem_req_t          mem_req,
    input  node_t             rd_data,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EVAL  = 4'b0010,
        ST_CLEAR = 4'b0100,
        ST_EMIT  = 4'b1000
    } walk_state_t;

    walk_state_t state_reg, state_next;

    // Request payload
    logic             req_type_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;

    // Trie and per-string state
    logic               root_present_reg, root_present_next;
    logic [FREE_W-1:0]  next_free_reg, next_free_next;
    ptr_t               cursor_reg, cursor_next;
    logic               stopped_reg, stopped_next;
    logic               overflow_reg, overflow_next;
    logic [QLEN_W-1:0]  followed_reg, followed_next;
    logic [TOTAL_W-1:0] checked_reg, checked_next;
    logic [TOTAL_W-1:0] mapped_reg, mapped_next;
    ptr_t               clear_addr_reg, clear_addr_next;
    result_t            res_reg, res_next;

    letter_t letter;
    node_t   node_data;
    ptr_t    child;
    ptr_t    free_ptr;
    logic    alloc;
    logic    match;

    assign letter    = letter_slot(symbol_reg);
    // Before the root exists the root node reads as cleared
    assign node_data = root_present_reg ? rd_data : '0;
    assign child     = node_data[letter.slot];
    assign free_ptr  = next_free_reg[PTR_W-1:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    // Evaluate one character against the node read from memory
    always_comb begin
        state_next        = state_reg;
        root_present_next = root_present_reg;
        next_free_next    = next_free_reg;
        cursor_next       = cursor_reg;
        stopped_next      = stopped_reg;
        overflow_next     = overflow_reg;
        followed_next     = followed_reg;
        checked_next      = checked_reg;
        mapped_next       = mapped_reg;
        clear_addr_next   = clear_addr_reg;
        res_next          = res_reg;
        alloc             = 1'b0;
        match             = 1'b0;
        mem_req.wr_en     = 1'b0;
        mem_req.wr_addr   = cursor_reg;
        mem_req.wr_data   = '0;
        mem_req.rd_addr   = cursor_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (req_type_reg == REQ_INSERT) begin
                    if (!stopped_reg) begin
                        // Create and clear the root on the first insert
                        if (!root_present_reg) begin
                            root_present_next = 1'b1;
                            mem_req.wr_en     = 1'b1;
                        end
                        if (!letter.is_dna) begin
                            stopped_next = 1'b1;
                        end else if (child != '0) begin
                            cursor_next = child;
                        end else if (next_free_reg >= FREE_W'(NODE_COUNT)) begin
                            overflow_next = 1'b1;
                            stopped_next  = 1'b1;
                        end else begin
                            // Link a fresh node and clear it next cycle
                            alloc                        = 1'b1;
                            mem_req.wr_en                = 1'b1;
                            mem_req.wr_data              = node_data;
                            mem_req.wr_data[letter.slot] = free_ptr;
                            cursor_next                  = free_ptr;
                            clear_addr_next              = free_ptr;
                            next_free_next               = next_free_reg + 1'b1;
                        end
                    end
                end else begin
                    if (!stopped_reg && (followed_reg < query_length)) begin
                        followed_next = followed_reg + 1'b1;
                        if (!root_present_reg) begin
                            stopped_next = 1'b1;
                        end else if (letter.is_dna) begin
                            if (child == '0) begin
                                stopped_next = 1'b1;
                            end else begin
                                cursor_next = child;
                            end
                        end
                    end
                end

                // Close the string: build the result and drop per-string state
                if (last_reg) begin
                    if (req_type_reg == REQ_CHECK) begin
                        match = root_present_next && !stopped_next;
                        if (checked_reg != '1) begin
                            checked_next = checked_reg + 1'b1;
                        end
                        if (match && (mapped_reg != '1)) begin
                            mapped_next = mapped_reg + 1'b1;
                        end
                    end
                    res_next.op_done         = req_type_reg;
                    res_next.matched         = match;
                    res_next.pool_overflow   = (req_type_reg == REQ_INSERT) && overflow_next;
                    res_next.strings_checked = checked_next;
                    res_next.strings_mapped  = mapped_next;
                    cursor_next   = '0;
                    stopped_next  = 1'b0;
                    overflow_next = 1'b0;
                    followed_next = '0;
                end

                if (alloc) begin
                    state_next = ST_CLEAR;
                end else if (last_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clear_addr_reg;
                state_next      = last_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            root_present_reg <= 1'b0;
            next_free_reg    <= FREE_W'(1);
            cursor_reg       <= '0;
            stopped_reg      <= 1'b0;
            overflow_reg     <= 1'b0;
            followed_reg     <= '0;
            checked_reg      <= '0;
            mapped_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            root_present_reg <= root_present_next;
            next_free_reg    <= next_free_next;
            cursor_reg       <= cursor_next;
            stopped_reg      <= stopped_next;
            overflow_reg     <= overflow_next;
            followed_reg     <= followed_next;
            checked_reg      <= checked_next;
            mapped_reg       <= mapped_next;
        end
    end

    // Capture request payload and pending result
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg <= s_req_type;
            symbol_reg   <= s_symbol;
            last_reg     <= s_last_char;
        end
        clear_addr_reg <= clear_addr_next;
        res_reg        <= res_next;
    end

endmodule

// ----- src/dna_trie_insert_and_match.sv -----
// Four-way trie over the DNA letters a, t, c and g, kept in a single-port-write
// node memory of NODE_COUNT nodes. Each request carries one character, marked
// insert or check, and a last-character flag; the last character of a string
// yields one result with the match flag, the pool overflow flag and the running
// saturating totals of checked and matched strings. The cursor node is read
// from memory as the character is accepted; it is then evaluated and any new
// child pointer is written back. A character that allocates a node also passes
// a clear step, since the fresh node is cleared by a second write to the same
// port. A last character then hands its result to the output register,
// waiting while that register is still held by the sink. The node memory
// needs no clearing pass after reset: every node is cleared when it is
// allocated. query_length is register 0 at byte address 0 of the APB port.
`include "dna_trie_insert_and_match_assert.svh"

module dna_trie_insert_and_match
    import dtm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [SYM_W-1:0]   s_symbol,
    input  logic               s_last_char,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_op_done,
    output logic               m_matched,
    output logic               m_pool_overflow,
    output logic [TOTAL_W-1:0] m_strings_checked,
    output logic [TOTAL_W-1:0] m_strings_mapped,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [QLEN_W-1:0] query_length;
    mem_req_t          mem_req;
    node_t             rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           m_res_reg;

    dtm_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .query_length (query_length)
    );

    dtm_node_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    dtm_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_symbol     (s_symbol),
        .s_last_char  (s_last_char),
        .query_length (query_length),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_op_done         = m_res_reg.op_done;
    assign m_matched         = m_res_reg.matched;
    assign m_pool_overflow   = m_res_reg.pool_overflow;
    assign m_strings_checked = m_res_reg.strings_checked;
    assign m_strings_mapped  = m_res_reg.strings_mapped;

    // One character in flight at a time
    `DTM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A pending result blocks new requests
    `DTM_ASSERT_SAME(a_result_blocks_input, aclk, aresetn, res_valid, !s_ready)
    // Matched strings never outnumber checked strings
    `DTM_ASSERT_SAME(a_mapped_le_checked, aclk, aresetn, m_valid,
        m_strings_mapped <= m_strings_checked)
    // Match belongs to checks only, overflow to inserts only
    `DTM_ASSERT_SAME(a_flags_by_type, aclk, aresetn, m_valid,
        !(m_matched && !m_op_done) && !(m_pool_overflow && m_op_done))

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import dtm_pkg::*;
();

    localparam int MAX_LEN     = 20;
    localparam int LIB_DEPTH   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_INSERT;
    logic [SYM_W-1:0]   s_symbol = '0;
    logic               s_last_char = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_op_done;
    logic               m_matched;
    logic               m_pool_overflow;
    logic [TOTAL_W-1:0] m_strings_checked;
    logic [TOTAL_W-1:0] m_strings_mapped;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dna_trie_insert_and_match i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_symbol          (s_symbol),
        .s_last_char       (s_last_char),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_op_done         (m_op_done),
        .m_matched         (m_matched),
        .m_pool_overflow   (m_pool_overflow),
        .m_strings_checked (m_strings_checked),
        .m_strings_mapped  (m_strings_mapped),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Trie shadow: child pointers, pool and per-string walk state
    ptr_t               child_ptr [NODE_COUNT][4];
    logic               root_built = 1'b0;
    logic [FREE_W-1:0]  free_node = FREE_W'(1);
    ptr_t               walk_node = '0;
    logic               walk_stopped = 1'b0;
    logic               pool_ran_out = 1'b0;
    logic [QLEN_W-1:0]  letters_walked = '0;
    logic [QLEN_W-1:0]  prefix_len = QLEN_RESET;
    logic [TOTAL_W-1:0] checked_sum = '0;
    logic [TOTAL_W-1:0] mapped_sum = '0;

    result_t            pending_results [$];
    result_t            want_result;
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    // Strings already inserted, reused to build checks that can match
    logic [SYM_W-1:0]   lib_sym [LIB_DEPTH][MAX_LEN];
    int                 lib_len [LIB_DEPTH];
    int                 lib_fill = 0;

    // String under construction
    logic [SYM_W-1:0]   str_sym [MAX_LEN];
    logic               str_req [MAX_LEN];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dna_trie_insert_and_match: mismatch");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int base_slot(input logic [SYM_W-1:0] sym);
        case (sym)
            CHAR_A:  return int'(SLOT_A);
            CHAR_T:  return int'(SLOT_T);
            CHAR_C:  return int'(SLOT_C);
            CHAR_G:  return int'(SLOT_G);
            default: return -1;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] rand_base();
        case ($urandom_range(3))
            0:       return CHAR_A;
            1:       return CHAR_T;
            2:       return CHAR_C;
            default: return CHAR_G;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] rand_other();
        logic [SYM_W-1:0] s;
        do s = SYM_W'($urandom_range(255)); while (base_slot(s) >= 0);
        return s;
    endfunction

    task automatic clear_node(input ptr_t n);
        for (int k = 0; k < 4; k++) child_ptr[n][k] = '0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected %0h, got %0h", what, want, got);
    endtask

    // Walk the shadow trie for one accepted character, queueing a result if last
    task automatic predict_char(input logic req, input logic [SYM_W-1:0] sym,
                                input logic last);
        int      slot;
        ptr_t    nxt;
        result_t r;
        slot = base_slot(sym);
        if (req == REQ_INSERT) begin
            if (!walk_stopped) begin
                if (!root_built) begin
                    root_built = 1'b1;
                    clear_node('0);
                    walk_node = '0;
                end
                if (slot < 0) begin
                    walk_stopped = 1'b1;
                end else begin
                    nxt = child_ptr[walk_node][slot];
                    if (nxt == '0 && free_node >= FREE_W'(NODE_COUNT)) begin
                        pool_ran_out = 1'b1;
                        walk_stopped = 1'b1;
                    end else begin
                        if (nxt == '0) begin
                            nxt = ptr_t'(free_node);
                            child_ptr[walk_node][slot] = nxt;
                            clear_node(nxt);
                            free_node = free_node + 1'b1;
                        end
                        walk_node = nxt;
                    end
                end
            end
        end else if (!walk_stopped && letters_walked < prefix_len) begin
            letters_walked = letters_walked + 1'b1;
            if (!root_built) begin
                walk_stopped = 1'b1;
            end else if (slot >= 0) begin
                nxt = child_ptr[walk_node][slot];
                if (nxt == '0) walk_stopped = 1'b1;
                else walk_node = nxt;
            end
        end

        if (last) begin
            r = '0;
            r.op_done = req;
            if (req == REQ_CHECK) begin
                r.matched = root_built && !walk_stopped;
                if (checked_sum != '1) checked_sum = checked_sum + 1'b1;
                if (r.matched && mapped_sum != '1) mapped_sum = mapped_sum + 1'b1;
            end else begin
                r.pool_overflow = pool_ran_out;
            end
            r.strings_checked = checked_sum;
            r.strings_mapped  = mapped_sum;
            pending_results.push_back(r);
            walk_node      = '0;
            walk_stopped   = 1'b0;
            pool_ran_out   = 1'b0;
            letters_walked = '0;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with no request pending", '0, 32'(m_op_done));
            end else begin
                want_result = pending_results.pop_front();
                if (m_op_done !== want_result.op_done)
                    note_mismatch("op_done", 32'(want_result.op_done), 32'(m_op_done));
                if (m_matched !== want_result.matched)
                    note_mismatch("matched", 32'(want_result.matched), 32'(m_matched));
                if (m_pool_overflow !== want_result.pool_overflow)
                    note_mismatch("pool_overflow", 32'(want_result.pool_overflow),
                                  32'(m_pool_overflow));
                if (m_strings_checked !== want_result.strings_checked)
                    note_mismatch("strings_checked", want_result.strings_checked,
                                  m_strings_checked);
                if (m_strings_mapped !== want_result.strings_mapped)
                    note_mismatch("strings_mapped", want_result.strings_mapped,
                                  m_strings_mapped);
            end
        end
    end

    // Send one character request; hold valid until it is taken
    task automatic send_char(input logic req, input logic [SYM_W-1:0] sym,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_symbol    <= sym;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_char(req, sym, last);
    endtask

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++)
            send_char(str_req[i], str_sym[i], i == len - 1);
    endtask

    task automatic save_string(input int len);
        int slot;
        if (lib_fill < LIB_DEPTH) begin
            slot = lib_fill;
            lib_fill++;
        end else begin
            slot = $urandom_range(LIB_DEPTH - 1);
        end
        lib_len[slot] = len;
        for (int i = 0; i < len; i++) lib_sym[slot][i] = str_sym[i];
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
    endtask

    // Write query_length over APB while the block is idle, then read it back
    task automatic write_query_length(input logic [QLEN_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_QUERY_LENGTH, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        prefix_len = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[QLEN_W-1:0] !== value)
            note_mismatch("query_length readback", 32'(value), 32'(prdata[QLEN_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Build one random string: insert, check (often from a saved insert) or noise
    task automatic send_random_string();
        int kind;
        int len;
        int pick;
        kind = $urandom_range(99);
        if (kind < 45) begin
            if (lib_fill > 0 && $urandom_range(3) == 0) begin
                pick = $urandom_range(lib_fill - 1);
                len  = lib_len[pick];
                for (int i = 0; i < len; i++) str_sym[i] = lib_sym[pick][i];
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    str_sym[i] = ($urandom_range(19) == 0) ? rand_other() : rand_base();
                save_string(len);
            end
            for (int i = 0; i < len; i++) str_req[i] = REQ_INSERT;
        end else if (kind < 90) begin
            if (lib_fill > 0 && $urandom_range(3) != 0) begin
                pick = $urandom_range(lib_fill - 1);
                len  = lib_len[pick] + $urandom_range(4) - 2;
                if (len < 1) len = 1;
                if (len > MAX_LEN) len = MAX_LEN;
                for (int i = 0; i < len; i++)
                    str_sym[i] = (i < lib_len[pick]) ? lib_sym[pick][i] : rand_base();
                if ($urandom_range(3) == 0)
                    str_sym[$urandom_range(len - 1)] =
                        $urandom_range(1) ? rand_base() : rand_other();
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) str_sym[i] = rand_base();
            end
            for (int i = 0; i < len; i++) str_req[i] = REQ_CHECK;
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                str_req[i] = 1'($urandom_range(1));
                str_sym[i] = $urandom_range(1) ? rand_base() : SYM_W'($urandom_range(255));
            end
        end
        send_string(len);
    endtask

    // Checks against a trie with no root
    task automatic test_empty_trie();
        send_char(REQ_CHECK, CHAR_A, 1'b1);
        send_char(REQ_CHECK, CHAR_G, 1'b0);
        send_char(REQ_CHECK, CHAR_A, 1'b1);
    endtask

    // Root built by a non-DNA insert, stopped inserts, hit and miss checks
    task automatic test_root_and_stop();
        send_char(REQ_INSERT, 8'h58, 1'b1);
        send_char(REQ_CHECK, 8'h7A, 1'b1);
        send_char(REQ_INSERT, CHAR_A, 1'b0);
        send_char(REQ_INSERT, CHAR_C, 1'b0);
        send_char(REQ_INSERT, 8'h35, 1'b0);
        send_char(REQ_INSERT, CHAR_G, 1'b1);
        send_char(REQ_INSERT, CHAR_T, 1'b0);
        send_char(REQ_INSERT, CHAR_G, 1'b0);
        send_char(REQ_INSERT, CHAR_C, 1'b0);
        send_char(REQ_INSERT, CHAR_A, 1'b1);
        send_char(REQ_CHECK, CHAR_A, 1'b0);
        send_char(REQ_CHECK, CHAR_C, 1'b0);
        send_char(REQ_CHECK, CHAR_G, 1'b1);
        send_char(REQ_CHECK, CHAR_A, 1'b0);
        send_char(REQ_CHECK, CHAR_C, 1'b1);
    endtask

    // Mixed request types in one string and symbol byte extremes
    task automatic test_mixed_and_extremes();
        send_char(REQ_CHECK, CHAR_A, 1'b0);
        send_char(REQ_INSERT, CHAR_G, 1'b1);
        send_char(REQ_CHECK, 8'h00, 1'b0);
        send_char(REQ_CHECK, 8'hFF, 1'b0);
        send_char(REQ_CHECK, CHAR_A, 1'b1);
    endtask

    // Random strings across prefix lengths, extremes included, and idle patterns
    task automatic test_query_sweep();
        int               start;
        logic [QLEN_W-1:0] qlen;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       qlen = 5'd0;
                1:       qlen = 5'd1;
                2:       qlen = 5'd16;
                3:       qlen = 5'd31;
                4:       qlen = 5'd5;
                5:       qlen = 5'd10;
                6:       qlen = 5'd13;
                default: qlen = 5'd3;
            endcase
            write_query_length(qlen);
            set_idle_mode(idle_mode_t'(phase % 4));
            start = items_sent;
            while (items_sent - start < 40) send_random_string();
        end
    endtask

    // Fill the node pool, run past it, then check against the full trie
    task automatic test_pool_overflow();
        int pick;
        write_query_length(5'd16);
        set_idle_mode(IDLE_SEND);
        while (free_node < FREE_W'(NODE_COUNT)) begin
            for (int i = 0; i < 16; i++) begin
                str_req[i] = REQ_INSERT;
                str_sym[i] = rand_base();
            end
            save_string(16);
            send_string(16);
        end
        set_idle_mode(IDLE_BOTH);
        for (int n = 0; n < 4; n++) begin
            for (int i = 0; i < 12; i++) begin
                str_req[i] = REQ_INSERT;
                str_sym[i] = rand_base();
            end
            send_string(12);
        end
        for (int n = 0; n < 20; n++) begin
            pick = $urandom_range(lib_fill - 1);
            for (int i = 0; i < lib_len[pick]; i++) begin
                str_req[i] = (n < 4) ? REQ_INSERT : REQ_CHECK;
                str_sym[i] = lib_sym[pick][i];
            end
            send_string(lib_len[pick]);
        end
        for (int n = 0; n < 20; n++) send_random_string();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_trie();
        test_root_and_stop();
        test_mixed_and_extremes();
        test_query_sweep();
        test_pool_overflow();

        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("dna_trie_insert_and_match: match");
        end else begin
            $display("dna_trie_insert_and_match: mismatch");
        end
        $finish;
    end

endmodule
